[design/rag_pkg.sv]
package rag_pkg;
	localparam int FIELD_WIDTH = 64;
	localparam int DEN_WIDTH = 63;
	localparam int STATUS_WIDTH = 2;

	localparam logic [STATUS_WIDTH-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_WIDTH-1:0] ST_OVF = 2'd1;
	localparam logic [STATUS_WIDTH-1:0] ST_ZDEN = 2'd2;

	// datapath operations
	localparam logic [2:0] OP_LOAD = 3'd0;
	localparam logic [2:0] OP_MUL1 = 3'd1;
	localparam logic [2:0] OP_MUL2 = 3'd2;
	localparam logic [2:0] OP_MUL3 = 3'd3;
	localparam logic [2:0] OP_ADD = 3'd4;
	localparam logic [2:0] OP_DIVSTART = 3'd5;
	localparam logic [2:0] OP_DIVSTEP = 3'd6;
	localparam logic [2:0] OP_COMMIT = 3'd7;

	// division purpose
	localparam logic [1:0] DV_GCD = 2'd0;
	localparam logic [1:0] DV_NUM = 2'd1;
	localparam logic [1:0] DV_DEN = 2'd2;

	typedef struct packed {
		logic       en;
		logic [2:0] op;
		logic [1:0] dv;
	} rag_cmd_t;

	typedef struct packed {
		logic zden;
		logic ovf;
		logic ps_zero;
		logic div_done;
		logic rem_zero;
		logic mul_done;
	} rag_stat_t;
endpackage

[design/rational_accumulator_gcd_reduce_top.sv]
// Rational accumulator: keeps a running fraction (0/1 after reset), adds each term
// by cross-multiplication, and reduces by Euclid gcd computed with a shared
// one-bit-per-cycle restoring divider. One request at a time: the checks, the
// three 64-bit products (all on one 32x32 multiplier) and the add, then the
// divider passes, then the result waits until taken. The gcd takes one pass per
// Euclid step, then two more for the reductions. A zero term denominator is
// answered from the checks, an overflow only after the products and the add.
// The divider sets the rate. Status 2 on zero denominator, 1 on overflow; the
// sum is then left unchanged.
module rational_accumulator_gcd_reduce_top import rag_pkg::*; #(
	parameter int VALUE_WIDTH = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    restart,
	input  logic [FIELD_WIDTH-1:0]  term_numerator,
	input  logic [DEN_WIDTH-1:0]    term_denominator,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [FIELD_WIDTH-1:0]  sum_numerator,
	output logic [DEN_WIDTH-1:0]    sum_denominator,
	output logic [STATUS_WIDTH-1:0] status
);
	rag_cmd_t  cmd;
	rag_stat_t stat;
	logic      in_take;

	rag_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .in_take, .out_valid, .out_stall,
		.status, .cmd, .stat
	);

	rag_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
		.clk, .arst_n, .in_take, .restart, .term_numerator, .term_denominator,
		.cmd, .stat, .sum_numerator, .sum_denominator
	);
endmodule

[design/rag_datapath.sv]
module rag_datapath import rag_pkg::*; #(
	parameter int VALUE_WIDTH = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_take,
	input  logic                    restart,
	input  logic [FIELD_WIDTH-1:0]  term_numerator,
	input  logic [DEN_WIDTH-1:0]    term_denominator,
	input  rag_cmd_t                cmd,
	output rag_stat_t               stat,
	output logic [FIELD_WIDTH-1:0]  sum_numerator,
	output logic [DEN_WIDTH-1:0]    sum_denominator
);
	localparam int W = FIELD_WIDTH;
	localparam int HW = W / 2;
	localparam int CW = $clog2(W + 1);
	localparam logic [W:0] HALF = {{(W-VALUE_WIDTH+1){1'b0}}, 1'b1, {(VALUE_WIDTH-1){1'b0}}};
	localparam logic [W:0] POSLIM = HALF - 1'b1;

	logic [W-1:0] rn_q, rd_q;
	logic [W-1:0] tmag_q, td_q;
	logic         tneg_q;
	logic [W-1:0] p1_q, p2_q, pd_q, ps_q;
	logic         n1_q, n2_q, ns_q, ovf_q;
	logic [W-1:0] ga_q, gb_q, g_q;
	logic [W-1:0] dvd_q, dvs_q, quo_q;
	logic [W-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0] qnum_q;
	logic [2*W-1:0] macc_q;
	logic [2:0]     mcnt_q;

	// product of two magnitudes, checked against the signed limit
	logic [W-1:0]   ma, mb;
	logic           mneg;
	logic [HW-1:0]  mpa, mpb;
	logic [W-1:0]   mpp;
	logic [2*W-1:0] mpp_sh;
	logic [W:0]     lim;
	logic           mbad;
	logic           mul_op, mul_last;
	logic           rneg;
	logic [W-1:0]   rmag;

	assign rneg = rn_q[W-1];
	assign rmag = rneg ? (~rn_q + 1'b1) : rn_q;

	always_comb begin
		ma = rmag;
		mb = td_q;
		mneg = rneg;
		case (cmd.op)
			OP_MUL1: begin
				ma = rmag; mb = td_q; mneg = rneg;
			end
			OP_MUL2: begin
				ma = tmag_q; mb = rd_q; mneg = tneg_q;
			end
			OP_MUL3: begin
				ma = rd_q; mb = td_q; mneg = 1'b0;
			end
			default: begin
				ma = rmag; mb = td_q; mneg = rneg;
			end
		endcase
		mneg = mneg && (ma != '0) && (mb != '0);
		// one half-by-half partial product per cycle, four in all
		mpa = mcnt_q[1] ? ma[W-1:HW] : ma[HW-1:0];
		mpb = mcnt_q[0] ? mb[W-1:HW] : mb[HW-1:0];
		mpp = mpa * mpb;
		case (mcnt_q[1:0])
			2'd0: mpp_sh = {{W{1'b0}}, mpp};
			2'd3: mpp_sh = {mpp, {W{1'b0}}};
			default: mpp_sh = {{HW{1'b0}}, mpp, {HW{1'b0}}};
		endcase
		lim = mneg ? HALF : POSLIM;
		mbad = (macc_q[2*W-1:W] != '0) || ({1'b0, macc_q[W-1:0]} > lim);
	end

	assign mul_op = cmd.en && (cmd.op inside {OP_MUL1, OP_MUL2, OP_MUL3});
	assign mul_last = mul_op && mcnt_q[2];

	always_ff @(posedge clk) begin
		if (in_take || mul_last) begin
			macc_q <= '0;
			mcnt_q <= '0;
		end else if (mul_op) begin
			macc_q <= macc_q + mpp_sh;
			mcnt_q <= mcnt_q + 1'b1;
		end
	end

	// sign-magnitude add
	logic [W:0] asum;
	logic [W:0] alim;
	logic       abad;
	logic [W-1:0] amag;
	logic       aneg;
	always_comb begin
		asum = {1'b0, p1_q} + {1'b0, p2_q};
		alim = n1_q ? HALF : POSLIM;
		abad = 1'b0;
		if (n1_q == n2_q) begin
			abad = asum > alim;
			amag = asum[W-1:0];
			aneg = n1_q && (amag != '0);
		end else if (p1_q >= p2_q) begin
			amag = p1_q - p2_q;
			aneg = n1_q && (amag != '0);
		end else begin
			amag = p2_q - p1_q;
			aneg = n2_q;
		end
	end

	// restoring divider step
	logic [W:0]   trial;
	logic [W-1:0] shrem;
	assign shrem = {rem_q[W-2:0], dvd_q[W-1]};
	assign trial = {rem_q, dvd_q[W-1]} - {1'b0, dvs_q};

	logic tbad;
	assign tbad = ({1'b0, tmag_q} > (tneg_q ? HALF : POSLIM)) || ({1'b0, td_q} > POSLIM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rn_q <= '0;
			rd_q <= {{(W-1){1'b0}}, 1'b1};
		end else if (in_take && restart) begin
			rn_q <= '0;
			rd_q <= {{(W-1){1'b0}}, 1'b1};
		end else if (cmd.en && cmd.op == OP_COMMIT) begin
			if (ps_q == '0) begin
				rn_q <= '0;
				rd_q <= {{(W-1){1'b0}}, 1'b1};
			end else begin
				rn_q <= ns_q ? (~qnum_q + 1'b1) : qnum_q;
				rd_q <= quo_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			tneg_q <= term_numerator[W-1];
			tmag_q <= term_numerator[W-1] ? (~term_numerator + 1'b1) : term_numerator;
			td_q <= {1'b0, term_denominator};
			ovf_q <= 1'b0;
		end else if (cmd.en) begin
			case (cmd.op)
				OP_LOAD: ovf_q <= tbad;
				OP_MUL1: begin
					if (mcnt_q[2]) begin
						p1_q <= macc_q[W-1:0]; n1_q <= mneg; ovf_q <= ovf_q | mbad;
					end
				end
				OP_MUL2: begin
					if (mcnt_q[2]) begin
						p2_q <= macc_q[W-1:0]; n2_q <= mneg; ovf_q <= ovf_q | mbad;
					end
				end
				OP_MUL3: begin
					if (mcnt_q[2]) begin
						pd_q <= macc_q[W-1:0]; ovf_q <= ovf_q | mbad;
					end
				end
				OP_ADD: begin
					ps_q <= amag; ns_q <= aneg; ovf_q <= ovf_q | abad;
					ga_q <= amag; gb_q <= pd_q;
				end
				OP_DIVSTART: begin
					case (cmd.dv)
						DV_GCD: begin dvd_q <= ga_q; dvs_q <= gb_q; end
						DV_NUM: begin dvd_q <= ps_q; dvs_q <= g_q; end
						DV_DEN: begin dvd_q <= pd_q; dvs_q <= g_q; end
						default: begin dvd_q <= ga_q; dvs_q <= gb_q; end
					endcase
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= CW'(W);
				end
				OP_DIVSTEP: begin
					if (!trial[W]) begin
						rem_q <= trial[W-1:0];
						quo_q <= {quo_q[W-2:0], 1'b1};
					end else begin
						rem_q <= shrem;
						quo_q <= {quo_q[W-2:0], 1'b0};
					end
					dvd_q <= {dvd_q[W-2:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
				end
				OP_COMMIT: begin
					case (cmd.dv)
						// euclid: (a, b) <- (b, a mod b)
						DV_GCD: begin ga_q <= gb_q; gb_q <= rem_q; g_q <= gb_q; end
						DV_NUM: qnum_q <= quo_q;
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	assign stat.zden = (td_q == '0);
	assign stat.ovf = ovf_q;
	assign stat.ps_zero = (ps_q == '0);
	assign stat.div_done = (cnt_q == '0);
	assign stat.rem_zero = (rem_q == '0);
	assign stat.mul_done = mcnt_q[2];

	assign sum_numerator = rn_q;
	assign sum_denominator = rd_q[DEN_WIDTH-1:0];
endmodule

[design/rag_ctrl.sv]
module rag_ctrl import rag_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	output logic                    in_take,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [STATUS_WIDTH-1:0] status,
	output rag_cmd_t                cmd,
	input  rag_stat_t               stat
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CHK = 4'd1;
	localparam logic [3:0] S_M1 = 4'd2;
	localparam logic [3:0] S_M2 = 4'd3;
	localparam logic [3:0] S_M3 = 4'd4;
	localparam logic [3:0] S_ADD = 4'd5;
	localparam logic [3:0] S_DST = 4'd6;
	localparam logic [3:0] S_DRUN = 4'd7;
	localparam logic [3:0] S_DFIN = 4'd8;
	localparam logic [3:0] S_OUT = 4'd9;
	localparam logic [3:0] S_FIN = 4'd10;

	logic [3:0] state_q, state_d;
	logic [1:0] dv_q, dv_d;
	logic [STATUS_WIDTH-1:0] status_q, status_d;

	assign in_stall = (state_q != S_IDLE);
	assign in_take = in_valid && !in_stall;
	assign out_valid = (state_q == S_OUT);
	assign status = status_q;

	always_comb begin
		state_d = state_q;
		dv_d = dv_q;
		status_d = status_q;
		cmd = '{en: 1'b0, op: OP_LOAD, dv: dv_q};
		case (state_q)
			S_IDLE: if (in_take) state_d = S_CHK;
			S_CHK: begin
				cmd.en = 1'b1; cmd.op = OP_LOAD;
				if (stat.zden) begin
					status_d = ST_ZDEN; state_d = S_OUT;
				end else state_d = S_M1;
			end
			S_M1: begin
				cmd.en = 1'b1; cmd.op = OP_MUL1;
				if (stat.mul_done) state_d = S_M2;
			end
			S_M2: begin
				cmd.en = 1'b1; cmd.op = OP_MUL2;
				if (stat.mul_done) state_d = S_M3;
			end
			S_M3: begin
				cmd.en = 1'b1; cmd.op = OP_MUL3;
				if (stat.mul_done) state_d = S_ADD;
			end
			S_ADD: begin
				cmd.en = 1'b1; cmd.op = OP_ADD;
				dv_d = DV_GCD; state_d = S_FIN;
			end
			S_FIN: begin
				if (stat.ovf) begin
					status_d = ST_OVF; state_d = S_OUT;
				end else if (stat.ps_zero) begin
					cmd.en = 1'b1; cmd.op = OP_COMMIT; cmd.dv = DV_DEN;
					status_d = ST_OK; state_d = S_OUT;
				end else state_d = S_DST;
			end
			S_DST: begin cmd.en = 1'b1; cmd.op = OP_DIVSTART; state_d = S_DRUN; end
			S_DRUN: begin
				cmd.en = 1'b1; cmd.op = OP_DIVSTEP;
				if (stat.div_done) begin
					cmd.en = 1'b0; state_d = S_DFIN;
				end
			end
			S_DFIN: begin
				cmd.en = 1'b1; cmd.op = OP_COMMIT;
				case (dv_q)
					DV_GCD: begin
						// remainder zero: divisor is the gcd
						if (stat.rem_zero) dv_d = DV_NUM;
						state_d = S_DST;
					end
					DV_NUM: begin dv_d = DV_DEN; state_d = S_DST; end
					default: begin status_d = ST_OK; state_d = S_OUT; end
				endcase
			end
			S_OUT: if (!out_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dv_q <= DV_GCD;
			status_q <= ST_OK;
		end else begin
			state_q <= state_d;
			dv_q <= dv_d;
			status_q <= status_d;
		end
	end

`ifndef ASSERT_OFF
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> !in_take) else $error("item taken while busy");
	a_out_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> !out_valid) else $error("result without work");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_OVF || status == ST_ZDEN))
		else $error("bad status");
`endif
endmodule
